>>> rtl/core/periodic_tick_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Periodic tick scheduler assertion macros
// Shared concurrent assertion forms for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TICK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TICK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pts_pkg.sv
// ----------------------------------------------------------------------------
// Periodic tick scheduler package
// Action and status codes, register indexes and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

    typedef enum logic [1:0] {
        ACT_ADVANCE    = 2'd0,
        ACT_BEGIN_PLAY = 2'd1,
        ACT_END_PLAY   = 2'd2,
        ACT_SET_ENABLE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_LIFECYCLE = 2'd1,
        ST_NONMONO   = 2'd2,
        ST_CANNOT    = 2'd3
    } t_status;

    localparam logic [1:0] REG_INTERVAL      = 2'd0;
    localparam logic [1:0] REG_CAN_EVER_TICK = 2'd1;
    localparam logic [1:0] REG_START_ENABLED = 2'd2;

    localparam int CFG_DATA_BITS = 32;

    typedef struct packed {
        logic playing;
        logic reset_pending;
        logic enable_flag;
    } t_flags;

    typedef struct packed {
        t_status     status;
        logic        ticked;
        logic [63:0] tick_time_ms;
        logic [31:0] delta_ms;
        logic        enabled_now;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/pts_step.sv
// ----------------------------------------------------------------------------
// Scheduler step logic
// Next state and result for one item, from the current state and the item.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_step #(
    parameter int TIME_BITS  = 64,
    parameter int DELTA_BITS = 32
) (
    input  pts_pkg::t_action        i_action,
    input  logic [TIME_BITS-1:0]    i_now,
    input  logic                    i_enable_value,
    input  logic [31:0]             i_interval,
    input  logic                    i_can_ever_tick,
    input  pts_pkg::t_flags         i_flags,
    input  logic [TIME_BITS-1:0]    i_last,
    input  logic [TIME_BITS-1:0]    i_prev,
    input  logic [TIME_BITS-1:0]    i_due,
    output pts_pkg::t_flags         o_flags,
    output logic [TIME_BITS-1:0]    o_last,
    output logic [TIME_BITS-1:0]    o_prev,
    output logic [TIME_BITS-1:0]    o_due,
    output pts_pkg::t_result        o_result
);
    import pts_pkg::*;

    localparam int SUM_W = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
    localparam int DW    = (TIME_BITS > DELTA_BITS) ? TIME_BITS : DELTA_BITS;
    localparam logic [SUM_W-1:0] TMAX_SUM =
        {{(SUM_W-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};
    localparam logic [DW-1:0] DMAX = {DW{1'b1}} >> (DW - DELTA_BITS);

    logic [SUM_W-1:0]     w_sum;
    logic [TIME_BITS-1:0] w_due_after;
    logic [TIME_BITS-1:0] w_diff;
    logic [DW-1:0]        w_diff_w;
    logic [DW-1:0]        w_dsat;
    logic [63:0]          w_dsat64;
    logic                 w_periodic;

    // next deadline, saturated at the top of the time range
    assign w_sum       = SUM_W'(i_now) + SUM_W'(i_interval);
    assign w_due_after = (w_sum > TMAX_SUM) ? {TIME_BITS{1'b1}} : w_sum[TIME_BITS-1:0];

    assign w_diff   = i_now - i_prev;
    assign w_diff_w = DW'(w_diff);
    assign w_dsat   = (w_diff_w > DMAX) ? DMAX : w_diff_w;
    assign w_dsat64 = 64'(w_dsat);

    assign w_periodic = (i_interval == 32'd0) || ((i_now >= i_due) && (i_now != i_prev));

    always_comb begin
        o_flags                = i_flags;
        o_last                 = i_last;
        o_prev                 = i_prev;
        o_due                  = i_due;
        o_result.status        = ST_OK;
        o_result.ticked        = 1'b0;
        o_result.tick_time_ms  = 64'd0;
        o_result.delta_ms      = 32'd0;

        case (i_action)
            ACT_ADVANCE: begin
                if (!i_flags.playing) begin
                    o_result.status = ST_LIFECYCLE;
                end else if (i_now < i_last) begin
                    o_result.status = ST_NONMONO;
                end else begin
                    o_last = i_now;
                    if (i_flags.enable_flag) begin
                        if (i_flags.reset_pending) begin
                            // first tick after a schedule reset: delta stays zero
                            o_flags.reset_pending = 1'b0;
                            o_prev                = i_now;
                            o_due                 = w_due_after;
                            o_result.ticked       = 1'b1;
                            o_result.tick_time_ms = 64'(i_now);
                        end else if (w_periodic) begin
                            o_prev                = i_now;
                            o_due                 = w_due_after;
                            o_result.ticked       = 1'b1;
                            o_result.tick_time_ms = 64'(i_now);
                            o_result.delta_ms     = w_dsat64[31:0];
                        end
                    end
                end
            end
            ACT_BEGIN_PLAY: begin
                o_last                = i_now;
                o_prev                = i_now;
                o_due                 = i_now;
                o_flags.playing       = 1'b1;
                o_flags.reset_pending = 1'b1;
            end
            ACT_END_PLAY: begin
                o_flags.playing = 1'b0;
            end
            ACT_SET_ENABLE: begin
                if (i_enable_value && !i_can_ever_tick) begin
                    o_result.status = ST_CANNOT;
                end else if (i_flags.enable_flag != i_enable_value) begin
                    o_flags.enable_flag   = i_enable_value;
                    o_flags.reset_pending = 1'b1;
                end
            end
            default: begin
                o_result.status = ST_OK;
            end
        endcase

        o_result.enabled_now = o_flags.enable_flag;
    end

endmodule

`default_nettype wire

>>> rtl/core/periodic_tick_scheduler.sv
// ----------------------------------------------------------------------------
// Periodic tick scheduler
// Decides per item whether a periodic tick is due; one result per item.
// Input channel: i_in_valid/o_in_ready with action, now_ms, enable_value.
// Output channel: o_out_valid/i_out_ready with status, ticked, tick time,
// saturated delta and the enable flag after the item.
// Config: i_cfg_we/i_cfg_addr/i_cfg_wdata, to be written only while idle; the
// block does not enforce it. Writing the interval arms a schedule reset; the
// two enable registers reload the flag. An accepted item is registered in
// the input stage; its result is evaluated and registered in the result stage.
// Throughput: one item per cycle unless stalled; the 64-bit compare/add path
// from input register through step logic to result register is the limit.
// Reset clears all timing state, flags and both stages; enable starts at 1.
// o_in_ready is held low while reset is asserted.
// A stalled receiver holds the result; one more item waits in the input
// register, after which o_in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_tick_scheduler #(
    parameter int TIME_BITS  = 64,
    parameter int DELTA_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_now_ms,
    input  logic        i_enable_value,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_ticked,
    output logic [63:0] o_tick_time_ms,
    output logic [31:0] o_delta_ms,
    output logic        o_enabled_now
);
    import pts_pkg::*;
    `include "periodic_tick_scheduler_defines.svh"

    // input stage
    logic                 r_in_valid;
    t_action              r_in_action;
    logic [TIME_BITS-1:0] r_in_now;
    logic                 r_in_enable;

    // configuration
    logic [31:0]          r_interval;
    logic                 r_can_ever_tick;
    logic                 r_start_enabled;

    // scheduler state
    t_flags               r_flags;
    t_flags               n_flags;
    logic [TIME_BITS-1:0] r_last;
    logic [TIME_BITS-1:0] r_prev;
    logic [TIME_BITS-1:0] r_due;

    // result stage
    logic                 r_out_valid;
    t_result              r_out;

    t_flags               w_step_flags;
    logic [TIME_BITS-1:0] w_step_last;
    logic [TIME_BITS-1:0] w_step_prev;
    logic [TIME_BITS-1:0] w_step_due;
    t_result              w_step_result;
    logic                 w_adv;
    logic                 w_in_acc;

    // move the held item into the result register
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_in_valid || w_adv);
    assign w_in_acc   = i_in_valid && o_in_ready;

    pts_step #(
        .TIME_BITS  (TIME_BITS),
        .DELTA_BITS (DELTA_BITS)
    ) u_step (
        .i_action        (r_in_action),
        .i_now           (r_in_now),
        .i_enable_value  (r_in_enable),
        .i_interval      (r_interval),
        .i_can_ever_tick (r_can_ever_tick),
        .i_flags         (r_flags),
        .i_last          (r_last),
        .i_prev          (r_prev),
        .i_due           (r_due),
        .o_flags         (w_step_flags),
        .o_last          (w_step_last),
        .o_prev          (w_step_prev),
        .o_due           (w_step_due),
        .o_result        (w_step_result)
    );

    // flag update: config writes win; write them only while idle (not enforced)
    always_comb begin
        n_flags = w_adv ? w_step_flags : r_flags;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_INTERVAL: begin
                    n_flags.reset_pending = 1'b1;
                end
                REG_CAN_EVER_TICK: begin
                    n_flags.enable_flag = i_cfg_wdata[0] && r_start_enabled;
                end
                REG_START_ENABLED: begin
                    n_flags.enable_flag = r_can_ever_tick && i_cfg_wdata[0];
                end
                default: begin
                    n_flags = r_flags;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_interval      <= 32'd0;
            r_can_ever_tick <= 1'b1;
            r_start_enabled <= 1'b1;
            r_flags         <= '{playing: 1'b0, reset_pending: 1'b0, enable_flag: 1'b1};
            r_last          <= '0;
            r_prev          <= '0;
            r_due           <= '0;
        end else begin
            r_flags <= n_flags;
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_INTERVAL) begin
                    r_interval <= i_cfg_wdata;
                end
                if (i_cfg_addr == REG_CAN_EVER_TICK) begin
                    r_can_ever_tick <= i_cfg_wdata[0];
                end
                if (i_cfg_addr == REG_START_ENABLED) begin
                    r_start_enabled <= i_cfg_wdata[0];
                end
            end
            if (w_adv) begin
                r_last <= w_step_last;
                r_prev <= w_step_prev;
                r_due  <= w_step_due;
            end
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_action <= t_action'(i_action);
            r_in_now    <= i_now_ms[TIME_BITS-1:0];
            r_in_enable <= i_enable_value;
        end
        if (w_adv) begin
            r_out <= w_step_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_ticked       = r_out.ticked;
    assign o_tick_time_ms = r_out.tick_time_ms;
    assign o_delta_ms     = r_out.delta_ms;
    assign o_enabled_now  = r_out.enabled_now;

    `PTS_ASSERT_SAME(a_tick_ok, i_clk, i_rst_n,
        r_out_valid && r_out.ticked, r_out.status == ST_OK,
        "tick reported with error status")
    `PTS_ASSERT_SAME(a_idle_zero, i_clk, i_rst_n,
        r_out_valid && !r_out.ticked,
        (r_out.tick_time_ms == 64'd0) && (r_out.delta_ms == 32'd0),
        "tick fields set without a tick")
    `PTS_ASSERT_NEXT(a_begin_arms, i_clk, i_rst_n,
        w_adv && (r_in_action == ACT_BEGIN_PLAY) && !i_cfg_we,
        r_flags.playing && r_flags.reset_pending,
        "begin play did not arm the schedule")
    `PTS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n,
        r_in_valid && !w_adv, r_in_valid,
        "held item dropped from the input stage")

endmodule

`default_nettype wire
